// ----- src/udiv32_pkg.sv -----
// Shared types and constants of the 32-bit unsigned divider.
`timescale 1ns / 1ps
`default_nettype none

package udiv32_pkg;

  localparam int unsigned WordBits = 32;
  localparam int unsigned CntBits  = $clog2(WordBits);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_HOLD
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic step;
    logic publish;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic last_step;
  } stat_t;

endpackage

`default_nettype wire

// ----- src/udiv32_dp.sv -----
// Datapath of the divider: shift-subtract registers, step counter and result register.
`timescale 1ns / 1ps
`default_nettype none

module udiv32_dp (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire udiv32_pkg::cmd_t                  cmd_i,
  output udiv32_pkg::stat_t                      stat_o,
  input  wire logic [udiv32_pkg::WordBits-1:0]   dividend_i,
  input  wire logic [udiv32_pkg::WordBits-1:0]   divisor_i,
  output logic      [udiv32_pkg::WordBits-1:0]   quotient_o,
  output logic      [udiv32_pkg::WordBits-1:0]   remainder_o,
  output logic                                   divide_by_zero_o
);

  localparam int unsigned W = udiv32_pkg::WordBits;

  logic [W-1:0]                     rem_q, rem_d;
  logic [W-1:0]                     quo_q, quo_d;
  logic [W-1:0]                     div_q, div_d;
  logic                             dbz_q, dbz_d;
  logic [udiv32_pkg::CntBits-1:0]   cnt_q, cnt_d;
  logic [W:0]                       trial;
  logic [W:0]                       diff;
  logic                             fits;
  logic [W-1:0]                     quo_out_q;
  logic [W-1:0]                     rem_out_q;
  logic                             dbz_out_q;

  // one restoring step: bring down the next dividend bit, try the subtract
  assign trial = {rem_q, quo_q[W-1]};
  assign diff  = trial - {1'b0, div_q};
  assign fits  = ~diff[W];

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    div_d = div_q;
    dbz_d = dbz_q;
    cnt_d = cnt_q;
    if (cmd_i.load) begin
      rem_d = '0;
      quo_d = dividend_i;
      div_d = divisor_i;
      dbz_d = (divisor_i == '0);
      cnt_d = udiv32_pkg::CntBits'(W - 1);
    end else if (cmd_i.step) begin
      rem_d = fits ? diff[W-1:0] : trial[W-1:0];
      quo_d = {quo_q[W-2:0], fits};
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_d;
    dbz_q <= dbz_d;
    if (cmd_i.publish) begin
      quo_out_q <= quo_q;
      rem_out_q <= rem_q;
      dbz_out_q <= dbz_q;
    end
  end

  assign stat_o.last_step = (cnt_q == '0);
  assign quotient_o       = quo_out_q;
  assign remainder_o      = rem_out_q;
  assign divide_by_zero_o = dbz_out_q;

endmodule

`default_nettype wire

// ----- src/udiv32_ctrl.sv -----
// Controller of the divider: sequencing state machine and output valid.
`timescale 1ns / 1ps
`default_nettype none

module udiv32_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  input  wire udiv32_pkg::stat_t  stat_i,
  output udiv32_pkg::cmd_t        cmd_o
);

  udiv32_pkg::state_e state_q, state_d;
  logic               out_valid_q, out_valid_d;
  logic               out_free;

  assign out_free = ~out_valid_q | out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      udiv32_pkg::ST_IDLE: if (in_valid_i)        state_d = udiv32_pkg::ST_RUN;
      udiv32_pkg::ST_RUN:  if (stat_i.last_step)  state_d = udiv32_pkg::ST_HOLD;
      udiv32_pkg::ST_HOLD: if (out_free)          state_d = udiv32_pkg::ST_IDLE;
      default:                                    state_d = udiv32_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      udiv32_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      udiv32_pkg::ST_RUN:  cmd_o.step    = 1'b1;
      udiv32_pkg::ST_HOLD: cmd_o.publish = out_free;
      default:             cmd_o         = '0;
    endcase
  end

  assign out_valid_d = cmd_o.publish | (out_valid_q & ~out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= udiv32_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // a result never overwrites one that is still waiting
  a_publish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.publish |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten while pending");

  a_publish_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.publish |=> out_valid_o)
    else $error("published result not offered");

  a_load_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == udiv32_pkg::ST_RUN) && !stat_i.last_step)
    else $error("load did not start a full run");

  a_last_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == udiv32_pkg::ST_RUN) && stat_i.last_step |=> state_q == udiv32_pkg::ST_HOLD)
    else $error("run did not finish into hold");

endmodule

`default_nettype wire

// ----- src/unsigned_divider_32_core.sv -----
// Top level of the 32-bit unsigned restoring divider.
//
// Requests arrive on the s_axis channel: tdata carries dividend and divisor.
// Results leave on the m_axis channel: tdata carries quotient and remainder,
// tuser flags a zero divisor (quotient all ones, remainder = dividend).
// One bit of quotient is produced per cycle by a single shift-subtract unit.
// A request is handled in order: the operands are loaded, 32 steps
// run, and the result moves into the output register. The block
// takes one request at a time; s_axis_tready is high only while idle.
// The next request is taken once the last result is in the output register.
// The result waits in the output register until taken; a new request is
// accepted meanwhile, and its finished result waits in the working
// registers until the output register is free.
// Reset (rst_ni low, asynchronous) returns the block to idle and drops
// m_axis_tvalid; any request in progress is lost.
`timescale 1ns / 1ps
`default_nettype none

module unsigned_divider_32_core (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  input  wire logic [2*udiv32_pkg::WordBits-1:0]   s_axis_tdata,  // divisor (high half), dividend (low half)
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  output logic      [2*udiv32_pkg::WordBits-1:0]   m_axis_tdata,  // remainder (high half), quotient (low half)
  output logic                                     m_axis_tuser   // divide_by_zero
);

  localparam int unsigned W = udiv32_pkg::WordBits;

  udiv32_pkg::cmd_t  cmd;
  udiv32_pkg::stat_t stat;
  logic [W-1:0]      quotient;
  logic [W-1:0]      remainder;

  udiv32_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  udiv32_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .dividend_i       (s_axis_tdata[W-1:0]),
    .divisor_i        (s_axis_tdata[2*W-1:W]),
    .quotient_o       (quotient),
    .remainder_o      (remainder),
    .divide_by_zero_o (m_axis_tuser)
  );

  assign m_axis_tdata = {remainder, quotient};

endmodule

`default_nettype wire
